@@ hw/rtl/pic_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types, command and register codes, and saturation helpers for the
// 2-D particle push core.
// ----------------------------------------------------------------------------
package pic_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } pic_cmd_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_KICK_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIES_ION   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ION_SCALE     = 3'd6;

    localparam logic signed [31:0] RST_KICK_GAIN     = 32'sd0;
    localparam logic [30:0]        RST_TIME_STEP     = 31'd1;
    localparam logic [30:0]        RST_INV_CELL_SIZE = 31'd65536;
    localparam logic [30:0]        RST_LENGTH_X      = 31'd16777216;
    localparam logic [30:0]        RST_LENGTH_Y      = 31'd8388608;
    localparam logic [31:0]        RST_ION_SCALE     = 32'd21691;

    localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
    localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        grid_index;
        logic signed [31:0] field_x_value;
        logic signed [31:0] field_y_value;
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
    } pic_in_t;

    typedef struct packed {
        logic signed [31:0] new_position_x;
        logic signed [31:0] new_position_y;
        logic signed [31:0] new_velocity_x;
        logic signed [31:0] new_velocity_y;
        logic               particle_lost;
        logic [31:0]        lost_count_total;
        logic [63:0]        lost_energy_total;
    } pic_out_t;

    function automatic logic signed [49:0] ext50(input logic signed [31:0] v);
        return {{18{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > SAT_MAX) begin
            return 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pic_particle_push_2d_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_particle_push_2d_core
// 2-D particle-in-cell push with bilinear field gather and loss accounting.
//
// Input channel s_valid/s_ready/s_data carries commands: a load writes one
// grid point of the x and y field memories, a clear zeroes the loss totals,
// and a push moves one particle. Only a push returns a result on
// m_valid/m_ready/m_data. The core takes no new input while a push is in
// flight: a sequencer drives one shared 33x33 multiplier and the single-port
// field memories, reading the four cell corners one per cycle, and the y row
// is reduced modulo the grid height eight bits per cycle. The result sits in
// an output register; the core accepts new input while it waits, and only
// stalls the end of the next push until the receiver has taken it. The user
// must write configuration through cfg_wr_en/cfg_index/cfg_wdata only while
// the core is idle; the core itself does not enforce this.
// Reset (aresetn low, synchronous) restores register defaults, clears the
// loss totals and the output valid; field memory contents are undefined
// until loaded.
// ----------------------------------------------------------------------------
module pic_particle_push_2d_core
    import pic_pkg::*;
#(
    parameter int GRID_X = 257,
    parameter int GRID_Y = 128
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire pic_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output pic_out_t                   m_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int POINTS = GRID_X * GRID_Y;
    localparam int AW     = $clog2(POINTS);
    localparam int XW     = $clog2(GRID_X);
    localparam int YW     = $clog2(GRID_Y);
    localparam int IW     = ((AW > 16) ? AW : 16) + 1;
    localparam logic signed [65:0] CX_MAX = 66'(GRID_X - 1) <<< 16;

    typedef enum logic [23:0] {
        ST_IDLE = 24'h000001,
        ST_CX   = 24'h000002,
        ST_CY   = 24'h000004,
        ST_MODS = 24'h000008,
        ST_MODW = 24'h000010,
        ST_RD   = 24'h000020,
        ST_L0   = 24'h000040,
        ST_L1   = 24'h000080,
        ST_L2   = 24'h000100,
        ST_L3   = 24'h000200,
        ST_L4   = 24'h000400,
        ST_L5   = 24'h000800,
        ST_K0   = 24'h001000,
        ST_K1   = 24'h002000,
        ST_P0   = 24'h004000,
        ST_P1   = 24'h008000,
        ST_RF   = 24'h010000,
        ST_E0   = 24'h020000,
        ST_E1   = 24'h040000,
        ST_E2   = 24'h080000,
        ST_E3   = 24'h100000,
        ST_E4   = 24'h200000,
        ST_E5   = 24'h400000,
        ST_DONE = 24'h800000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic signed [31:0] kick_gain_reg;
    logic [30:0]        time_step_reg;
    logic [30:0]        inv_cell_reg;
    logic [30:0]        length_x_reg;
    logic [30:0]        length_y_reg;
    logic               ion_reg;
    logic [31:0]        ion_scale_reg;

    // particle and gather datapath
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic [XW-1:0]      jx_reg;
    logic [16:0]        fx_reg;
    logic [15:0]        fy_reg;
    logic [YW-1:0]      y0_reg, y1_reg;
    logic [2:0]         rc_reg;
    logic signed [31:0] xc_reg [4];
    logic signed [31:0] yc_reg [4];
    logic signed [31:0] elo_x_reg, ehi_x_reg, elo_y_reg, ehi_y_reg;
    logic signed [31:0] ex_reg, ey_reg;
    logic               lost_reg;
    logic [63:0]        e_reg, t_reg;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    // totals and output
    logic [31:0] cnt_reg, cnt_next;
    logic [63:0] esum_reg, esum_next;
    logic [64:0] esum_add;
    pic_out_t    out_reg;
    logic        m_valid_reg;

    logic               s_fire, out_free, done_fire, clear_fire;
    logic [IW-1:0]      idx_w;
    logic               grid_we;
    logic [AW-1:0]      grid_addr, rd_addr;
    logic [XW-1:0]      rd_x;
    logic [YW-1:0]      rd_y;
    logic [31:0]        fx_rdata, fy_rdata;
    logic signed [65:0] cx_full;
    logic signed [31:0] lerp_val;
    logic signed [31:0] py_wrap;
    logic signed [49:0] ly50;
    logic               ym_done;
    logic [YW-1:0]      ym_y0, ym_y1;
    logic [1:0]         cap_idx;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign done_fire  = (state_reg == ST_DONE) && out_free;
    assign clear_fire = s_fire && (s_data.command == CMD_CLEAR);

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kick_gain_reg <= RST_KICK_GAIN;
            time_step_reg <= RST_TIME_STEP;
            inv_cell_reg  <= RST_INV_CELL_SIZE;
            length_x_reg  <= RST_LENGTH_X;
            length_y_reg  <= RST_LENGTH_Y;
            ion_reg       <= 1'b0;
            ion_scale_reg <= RST_ION_SCALE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_KICK_GAIN:     kick_gain_reg <= cfg_wdata;
                CFG_TIME_STEP:     time_step_reg <= cfg_wdata[30:0];
                CFG_INV_CELL_SIZE: inv_cell_reg  <= cfg_wdata[30:0];
                CFG_LENGTH_X:      length_x_reg  <= cfg_wdata[30:0];
                CFG_LENGTH_Y:      length_y_reg  <= cfg_wdata[30:0];
                CFG_SPECIES_ION:   ion_reg       <= cfg_wdata[0];
                CFG_ION_SCALE:     ion_scale_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // field memories
    // ------------------------------------------------------------------
    assign idx_w   = IW'(s_data.grid_index);
    assign grid_we = s_fire && (s_data.command == CMD_LOAD) && (idx_w < IW'(POINTS));

    always_comb begin
        rd_x    = jx_reg + XW'(rc_reg[1]);
        rd_y    = rc_reg[0] ? y1_reg : y0_reg;
        rd_addr = AW'(rd_x) * AW'(GRID_Y) + AW'(rd_y);
    end

    assign grid_addr = grid_we ? AW'(idx_w) : rd_addr;

    pic_ram #(.WIDTH(32), .DEPTH(POINTS)) u_field_x (
        .aclk  (aclk),
        .we    (grid_we),
        .addr  (grid_addr),
        .wdata (s_data.field_x_value),
        .rdata (fx_rdata)
    );

    pic_ram #(.WIDTH(32), .DEPTH(POINTS)) u_field_y (
        .aclk  (aclk),
        .we    (grid_we),
        .addr  (grid_addr),
        .wdata (s_data.field_y_value),
        .rdata (fy_rdata)
    );

    pic_ymod #(.GRID_Y(GRID_Y)) u_ymod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_MODS),
        .jy      (prod_reg[62:32]),
        .done    (ym_done),
        .y0      (ym_y0),
        .y1      (ym_y1)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire && s_data.command == CMD_PUSH) state_next = ST_CX;
            ST_CX:   state_next = ST_CY;
            ST_CY:   state_next = ST_MODS;
            ST_MODS: state_next = ST_MODW;
            ST_MODW: if (ym_done) state_next = ST_RD;
            ST_RD:   if (rc_reg == 3'd4) state_next = ST_L0;
            ST_L0:   state_next = ST_L1;
            ST_L1:   state_next = ST_L2;
            ST_L2:   state_next = ST_L3;
            ST_L3:   state_next = ST_L4;
            ST_L4:   state_next = ST_L5;
            ST_L5:   state_next = ST_K0;
            ST_K0:   state_next = ST_K1;
            ST_K1:   state_next = ST_P0;
            ST_P0:   state_next = ST_P1;
            ST_P1:   state_next = ST_RF;
            ST_RF:   state_next = ST_E0;
            ST_E0:   state_next = ST_E1;
            ST_E1:   state_next = ST_E2;
            ST_E2:   state_next = ST_E3;
            ST_E3:   state_next = ST_E4;
            ST_E4:   state_next = ST_E5;
            ST_E5:   state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_CX: begin
                mul_a = {px_reg[31], px_reg};
                mul_b = {2'b00, inv_cell_reg};
            end
            ST_CY: begin
                mul_a = {py_reg[31], py_reg};
                mul_b = {2'b00, inv_cell_reg};
            end
            ST_L0: begin
                mul_a = {xc_reg[1][31], xc_reg[1]} - {xc_reg[0][31], xc_reg[0]};
                mul_b = {17'd0, fy_reg};
            end
            ST_L1: begin
                mul_a = {xc_reg[3][31], xc_reg[3]} - {xc_reg[2][31], xc_reg[2]};
                mul_b = {17'd0, fy_reg};
            end
            ST_L2: begin
                mul_a = {yc_reg[1][31], yc_reg[1]} - {yc_reg[0][31], yc_reg[0]};
                mul_b = {17'd0, fy_reg};
            end
            ST_L3: begin
                mul_a = {yc_reg[3][31], yc_reg[3]} - {yc_reg[2][31], yc_reg[2]};
                mul_b = {17'd0, fy_reg};
            end
            ST_L4: begin
                mul_a = {ehi_x_reg[31], ehi_x_reg} - {elo_x_reg[31], elo_x_reg};
                mul_b = {16'd0, fx_reg};
            end
            ST_L5: begin
                mul_a = {ehi_y_reg[31], ehi_y_reg} - {elo_y_reg[31], elo_y_reg};
                mul_b = {16'd0, fx_reg};
            end
            ST_K0: begin
                mul_a = {ex_reg[31], ex_reg};
                mul_b = {kick_gain_reg[31], kick_gain_reg};
            end
            ST_K1: begin
                mul_a = {ey_reg[31], ey_reg};
                mul_b = {kick_gain_reg[31], kick_gain_reg};
            end
            ST_P0: begin
                mul_a = {vx_reg[31], vx_reg};
                mul_b = {2'b00, time_step_reg};
            end
            ST_P1: begin
                mul_a = {vy_reg[31], vy_reg};
                mul_b = {2'b00, time_step_reg};
            end
            ST_E0: begin
                mul_a = {vx_reg[31], vx_reg};
                mul_b = {vx_reg[31], vx_reg};
            end
            ST_E1: begin
                mul_a = {vy_reg[31], vy_reg};
                mul_b = {vy_reg[31], vy_reg};
            end
            ST_E3: begin
                mul_a = {1'b0, e_reg[63:32]};
                mul_b = {1'b0, ion_scale_reg};
            end
            ST_E4: begin
                mul_a = {1'b0, e_reg[31:0]};
                mul_b = {1'b0, ion_scale_reg};
            end
            default: ;
        endcase
    end

    assign cx_full = prod_reg >>> 16;
    assign cap_idx = 2'(rc_reg - 3'd1);

    // a + (b - a) * w / 2^16, exact in 32 bits
    always_comb begin
        case (state_reg)
            ST_L1:   lerp_val = xc_reg[0] + prod_reg[47:16];
            ST_L2:   lerp_val = xc_reg[2] + prod_reg[47:16];
            ST_L3:   lerp_val = yc_reg[0] + prod_reg[47:16];
            ST_L4:   lerp_val = yc_reg[2] + prod_reg[47:16];
            ST_L5:   lerp_val = elo_x_reg + prod_reg[47:16];
            default: lerp_val = elo_y_reg + prod_reg[47:16];
        endcase
    end

    // totals and y wrap for the result
    always_comb begin
        ly50     = $signed({19'd0, length_y_reg});
        esum_add = {1'b0, esum_reg} + {1'b0, e_reg};
        cnt_next  = cnt_reg;
        esum_next = esum_reg;
        if (lost_reg) begin
            if (cnt_reg != 32'hffffffff) begin
                cnt_next = cnt_reg + 32'd1;
            end
            esum_next = esum_add[64] ? 64'hffffffffffffffff : esum_add[63:0];
        end
        if (ext50(py_reg) > ly50) begin
            py_wrap = sat32(ext50(py_reg) - ly50);
        end else if (py_reg < 0) begin
            py_wrap = sat32(ext50(py_reg) + ly50);
        end else begin
            py_wrap = py_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            esum_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clear_fire) begin
                cnt_reg  <= '0;
                esum_reg <= '0;
            end
            if (done_fire) begin
                cnt_reg     <= cnt_next;
                esum_reg    <= esum_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE: begin
                px_reg <= s_data.position_x;
                py_reg <= s_data.position_y;
                vx_reg <= s_data.velocity_x;
                vy_reg <= s_data.velocity_y;
            end
            ST_CY: begin
                // clamp to the grid; the last point uses the cell below it
                if (cx_full < 0) begin
                    jx_reg <= '0;
                    fx_reg <= '0;
                end else if (cx_full >= CX_MAX) begin
                    jx_reg <= XW'(GRID_X - 2);
                    fx_reg <= 17'h10000;
                end else begin
                    jx_reg <= cx_full[16 +: XW];
                    fx_reg <= {1'b0, cx_full[15:0]};
                end
            end
            ST_MODS: fy_reg <= prod_reg[31:16];
            ST_MODW: begin
                y0_reg <= ym_y0;
                y1_reg <= ym_y1;
                rc_reg <= '0;
            end
            ST_RD: begin
                rc_reg <= rc_reg + 3'd1;
                if (rc_reg != 3'd0) begin
                    xc_reg[cap_idx] <= fx_rdata;
                    yc_reg[cap_idx] <= fy_rdata;
                end
            end
            ST_L1:   elo_x_reg <= lerp_val;
            ST_L2:   ehi_x_reg <= lerp_val;
            ST_L3:   elo_y_reg <= lerp_val;
            ST_L4:   ehi_y_reg <= lerp_val;
            ST_L5:   ex_reg    <= lerp_val;
            ST_K0:   ey_reg    <= lerp_val;
            ST_K1:   vx_reg <= sat32(ext50(vx_reg) + $signed(prod_reg[65:16]));
            ST_P0:   vy_reg <= sat32(ext50(vy_reg) + $signed(prod_reg[65:16]));
            ST_P1:   px_reg <= sat32(ext50(px_reg) + $signed(prod_reg[65:16]));
            ST_RF: begin
                py_reg <= sat32(ext50(py_reg) + $signed(prod_reg[65:16]));
                // bounce off the closed x wall
                if (px_reg < 0) begin
                    px_reg <= sat32(-ext50(px_reg));
                    vx_reg <= sat32(-ext50(vx_reg));
                end
            end
            ST_E0:   lost_reg <= ext50(px_reg) >= $signed({19'd0, length_x_reg});
            ST_E1:   e_reg <= prod_reg[63:0];
            ST_E2:   e_reg <= e_reg + prod_reg[63:0];
            ST_E4:   t_reg <= prod_reg[63:0];
            ST_E5: begin
                if (ion_reg) begin
                    e_reg <= t_reg + {32'd0, prod_reg[63:32]};
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_reg.new_position_x    <= px_reg;
                    out_reg.new_position_y    <= py_wrap;
                    out_reg.new_velocity_x    <= vx_reg;
                    out_reg.new_velocity_y    <= vy_reg;
                    out_reg.particle_lost     <= lost_reg;
                    out_reg.lost_count_total  <= cnt_next;
                    out_reg.lost_energy_total <= esum_next;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_grid_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        grid_we |-> state_reg == ST_IDLE)
        else $error("field memory written while a push is in flight");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final push step");

    a_ymod_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        ym_done |-> state_reg == ST_MODW)
        else $error("row reduction finished while not awaited");

    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(clear_fire) |-> cnt_reg >= $past(cnt_reg))
        else $error("lost count went down without a clear");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");

endmodule
`default_nettype wire

@@ hw/rtl/pic_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module pic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ hw/rtl/pic_ymod.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_ymod
// Periodic y index unit: reduces a signed cell index modulo the grid height,
// eight dividend bits per cycle, and returns the row and the next row.
// ----------------------------------------------------------------------------
module pic_ymod #(
    parameter int GRID_Y = 128
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic signed [30:0]          jy,
    output logic                             done,
    output logic [$clog2(GRID_Y)-1:0]        y0,
    output logic [$clog2(GRID_Y)-1:0]        y1
);

    localparam int YW = $clog2(GRID_Y);
    localparam logic [YW:0] MODV = (YW + 1)'(GRID_Y);

    logic [31:0]   mag_reg;
    logic          neg_reg;
    logic [YW-1:0] rem_reg;
    logic [YW-1:0] rem_next;
    logic [1:0]    cnt_reg;
    logic          run_reg;
    logic          fin_reg;
    logic [31:0]   jy_ext;
    logic [YW:0]   y0_w;
    logic [YW:0]   y0_inc;

    assign jy_ext = {jy[30], jy};

    // restoring remainder, one dividend bit per step
    always_comb begin
        logic [YW:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < 8; i++) begin
            r = {r[YW-1:0], mag_reg[31-i]};
            if (r >= MODV) begin
                r = r - MODV;
            end
        end
        rem_next = r[YW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            fin_reg <= 1'b0;
            if (start) begin
                mag_reg <= jy[30] ? (32'd0 - jy_ext) : jy_ext;
                neg_reg <= jy[30];
                rem_reg <= '0;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                mag_reg <= mag_reg << 8;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    // fold a negative index back into range
    always_comb begin
        if (neg_reg && rem_reg != '0) begin
            y0_w = MODV - {1'b0, rem_reg};
        end else begin
            y0_w = {1'b0, rem_reg};
        end
        y0_inc = y0_w + 1'b1;
    end

    assign done = fin_reg;
    assign y0   = y0_w[YW-1:0];
    assign y1   = (y0_inc == MODV) ? '0 : y0_inc[YW-1:0];

endmodule
`default_nettype wire
